### hdl/tbrl_pkg.sv
// Token bucket rate limiter: shared types, codes and constants.
// Used by the front end, back end, top level and testbench; depends on nothing.
package tbrl_pkg;

  localparam logic [31:0] RATE_RST    = 32'd524288;
  localparam logic [31:0] BURST_RST   = 32'd1048576;
  localparam logic [15:0] ELAPSED_MAX = 16'd60000;
  localparam int unsigned MS_PER_S    = 1000;

  localparam int unsigned PROD_W    = 48;
  localparam int unsigned REFILL_W  = 38;
  localparam int unsigned DIV_DIGIT = 8;
  localparam int unsigned NDIV      = PROD_W / DIV_DIGIT;
  localparam int unsigned REM_W     = 10;

  localparam int unsigned MID_DEPTH = 8;
  localparam int unsigned OUT_DEPTH = 2;
  localparam int unsigned CRED_W    = $clog2(MID_DEPTH + 1);

  localparam logic REG_RATE  = 1'b0;
  localparam logic REG_BURST = 1'b1;

  typedef enum logic [1:0] {
    CMD_FETCH = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_SHUT  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    K_FETCH = 2'd0,
    K_BAD   = 2'd1,
    K_TICK  = 2'd2,
    K_SHUT  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_TIMEOUT  = 3'd1,
    ST_SHUTDOWN = 3'd2,
    ST_BAD      = 3'd3,
    ST_BUSY     = 3'd4
  } status_e;

  typedef struct packed {
    kind_e                kind;
    logic [31:0]          want;
    logic signed [16:0]   limit;
    logic [31:0]          elapsed;
    logic [REFILL_W-1:0]  refill;
  } item_t;

  typedef struct packed {
    status_e      status;
    logic [31:0]  granted;
    logic [31:0]  tokens;
    logic [63:0]  throttled;
  } res_t;

  // One radix-256 step of long division by MS_PER_S: {quotient digit, remainder}.
  function automatic logic [DIV_DIGIT+REM_W-1:0] div_digit(
    input logic [REM_W-1:0]     rem,
    input logic [DIV_DIGIT-1:0] bits
  );
    logic [REM_W:0]         r;
    logic [REM_W-1:0]       cur;
    logic [DIV_DIGIT-1:0]   q;
    cur = rem;
    q   = '0;
    for (int i = DIV_DIGIT - 1; i >= 0; i--) begin
      r = {cur, bits[i]};
      if (r >= (REM_W + 1)'(MS_PER_S)) begin
        q[i] = 1'b1;
        r    = r - (REM_W + 1)'(MS_PER_S);
      end
      cur = r[REM_W-1:0];
    end
    return {q, cur};
  endfunction

endpackage

### hdl/tbrl_fifo.sv
// Small register-based FIFO used between limiter stages.
// Depends on nothing; width and depth are parameters.
module tbrl_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

### hdl/tbrl_front.sv
// Front end: accept and classify transactions, clamp requests, compute refill.
// Depends on tbrl_pkg; feeds the work queue through a credit count.
module tbrl_front #(
  parameter int unsigned TOKEN_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  output logic                    full_o,
  input  logic [1:0]              cmd_i,
  input  logic [31:0]             amount_i,
  input  logic signed [16:0]      wait_limit_ms_i,
  input  logic [31:0]             rate_i,
  input  logic [TOKEN_WIDTH-1:0]  cap_i,
  input  logic                    mid_pop_i,
  output logic                    mid_push_o,
  output tbrl_pkg::item_t         mid_item_o
);

  import tbrl_pkg::*;

  localparam int unsigned CW = (TOKEN_WIDTH > 32) ? TOKEN_WIDTH : 32;

  typedef struct packed {
    item_t               item;
    logic [PROD_W-1:0]   num;
    logic [PROD_W-1:0]   quot;
    logic [REM_W-1:0]    rem;
  } div_t;

  div_t              stg_q [NDIV+1];
  div_t              stg_nxt [NDIV];
  div_t              entry;
  logic [NDIV:0]     vld_q;
  logic [CRED_W-1:0] credit_q, credit_d;
  logic              accept, keep, take;
  logic [15:0]       elapsed_clamp;

  assign full_o = (credit_q == CRED_W'(MID_DEPTH));
  assign accept = push_i && !full_o;

  always_comb begin
    keep  = 1'b0;
    entry = '0;
    entry.item.limit   = wait_limit_ms_i;
    entry.item.elapsed = amount_i;
    entry.item.want    = (CW'(amount_i) > CW'(cap_i)) ? 32'(cap_i) : amount_i;
    entry.item.kind    = K_FETCH;
    elapsed_clamp = (amount_i > 32'(ELAPSED_MAX)) ? ELAPSED_MAX : amount_i[15:0];
    entry.num = PROD_W'(rate_i) * PROD_W'(elapsed_clamp);
    unique case (cmd_i)
      CMD_FETCH: begin
        keep = 1'b1;
        entry.item.kind = (amount_i == '0) ? K_BAD : K_FETCH;
      end
      CMD_TICK: begin
        keep = (amount_i != '0);
        entry.item.kind = K_TICK;
      end
      CMD_SHUT: begin
        keep = 1'b1;
        entry.item.kind = K_SHUT;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign take = accept && keep;

  always_comb begin
    logic [DIV_DIGIT+REM_W-1:0] dig;
    for (int i = 0; i < NDIV; i++) begin
      dig = div_digit(stg_q[i].rem, stg_q[i].num[PROD_W-1 -: DIV_DIGIT]);
      stg_nxt[i].item = stg_q[i].item;
      stg_nxt[i].num  = stg_q[i].num << DIV_DIGIT;
      stg_nxt[i].quot = {stg_q[i].quot[PROD_W-DIV_DIGIT-1:0],
                         dig[DIV_DIGIT+REM_W-1 -: DIV_DIGIT]};
      stg_nxt[i].rem  = dig[REM_W-1:0];
    end
  end

  always_comb begin
    credit_d = credit_q;
    if (take && !mid_pop_i) begin
      credit_d = credit_q + CRED_W'(1);
    end else if (mid_pop_i && !take) begin
      credit_d = credit_q - CRED_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      credit_q <= '0;
    end else begin
      vld_q    <= {vld_q[NDIV-1:0], take};
      credit_q <= credit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      stg_q[0] <= entry;
    end
    for (int i = 0; i < NDIV; i++) begin
      stg_q[i+1] <= stg_nxt[i];
    end
  end

  always_comb begin
    mid_item_o        = stg_q[NDIV].item;
    mid_item_o.refill = stg_q[NDIV].quot[REFILL_W-1:0];
  end

  assign mid_push_o = vld_q[NDIV];

endmodule

### hdl/tbrl_back.sv
// Back end: bucket state, pending request, throttled total; issues results.
// Depends on tbrl_pkg; pops the work queue and pushes the result queue.
module tbrl_back #(
  parameter int unsigned TOKEN_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [TOKEN_WIDTH-1:0]  cap_i,
  input  logic                    mid_empty_i,
  input  tbrl_pkg::item_t         mid_item_i,
  output logic                    mid_pop_o,
  input  logic                    out_full_i,
  output logic                    out_push_o,
  output tbrl_pkg::res_t          out_res_o
);

  import tbrl_pkg::*;

  localparam int unsigned CW    = (TOKEN_WIDTH > 32) ? TOKEN_WIDTH : 32;
  localparam int unsigned SUM_W = ((TOKEN_WIDTH > REFILL_W) ? TOKEN_WIDTH : REFILL_W) + 1;
  localparam logic [63:0] TOKMAX64  = (64'd1 << TOKEN_WIDTH) - 64'd1;
  localparam logic [63:0] LVL_RST64 = (64'(BURST_RST) < TOKMAX64) ? 64'(BURST_RST) : TOKMAX64;

  typedef enum logic {
    S_LOAD,
    S_EXEC
  } state_e;

  state_e                  state_q, state_d;
  logic [TOKEN_WIDTH-1:0]  level_q, level_d;
  logic                    shut_q, shut_d;
  logic                    pend_q, pend_d;
  logic [31:0]             pbytes_q, pbytes_d;
  logic signed [16:0]      plimit_q, plimit_d;
  logic [31:0]             waited_q, waited_d;
  logic [63:0]             thr_q, thr_d;
  item_t                   cur_q, cur_d;

  logic [SUM_W-1:0]        sum;
  logic [TOKEN_WIDTH-1:0]  refilled, less;
  logic [32:0]             wsum;
  logic [31:0]             wsat, operand;
  logic                    ge, timed;

  always_comb begin
    sum      = SUM_W'(level_q) + SUM_W'(mid_item_i.refill);
    refilled = (sum > SUM_W'(cap_i)) ? cap_i : sum[TOKEN_WIDTH-1:0];
    wsum     = {1'b0, waited_q} + {1'b0, mid_item_i.elapsed};
    wsat     = wsum[32] ? '1 : wsum[31:0];
    operand  = (cur_q.kind == K_TICK) ? pbytes_q : cur_q.want;
    ge       = CW'(level_q) >= CW'(operand);
    less     = level_q - TOKEN_WIDTH'(operand);
    timed    = !plimit_q[16] && (waited_q >= 32'(plimit_q[15:0]));
  end

  always_comb begin
    state_d    = state_q;
    level_d    = level_q;
    shut_d     = shut_q;
    pend_d     = pend_q;
    pbytes_d   = pbytes_q;
    plimit_d   = plimit_q;
    waited_d   = waited_q;
    thr_d      = thr_q;
    cur_d      = cur_q;
    mid_pop_o  = 1'b0;
    out_push_o = 1'b0;
    out_res_o  = '0;
    out_res_o.status = ST_GRANTED;
    unique case (state_q)
      S_LOAD: begin
        if (!mid_empty_i) begin
          mid_pop_o = 1'b1;
          cur_d     = mid_item_i;
          state_d   = S_EXEC;
          if (mid_item_i.kind == K_TICK) begin
            level_d = refilled;
            if (pend_q) begin
              waited_d = wsat;
            end
          end
        end
      end
      S_EXEC: begin
        if (!out_full_i) begin
          state_d = S_LOAD;
          unique case (cur_q.kind)
            K_BAD: begin
              out_push_o       = 1'b1;
              out_res_o.status = ST_BAD;
            end
            K_SHUT: begin
              shut_d = 1'b1;
              if (pend_q) begin
                pend_d           = 1'b0;
                out_push_o       = 1'b1;
                out_res_o.status = ST_SHUTDOWN;
              end
            end
            K_FETCH: begin
              priority if (shut_q) begin
                out_push_o       = 1'b1;
                out_res_o.status = ST_SHUTDOWN;
              end else if (pend_q) begin
                out_push_o       = 1'b1;
                out_res_o.status = ST_BUSY;
              end else if (ge) begin
                level_d           = less;
                out_push_o        = 1'b1;
                out_res_o.status  = ST_GRANTED;
                out_res_o.granted = cur_q.want;
              end else begin
                thr_d = thr_q + 64'(cur_q.want);
                if (cur_q.limit == '0) begin
                  out_push_o       = 1'b1;
                  out_res_o.status = ST_TIMEOUT;
                end else begin
                  pend_d   = 1'b1;
                  pbytes_d = cur_q.want;
                  plimit_d = cur_q.limit;
                  waited_d = '0;
                end
              end
            end
            K_TICK: begin
              if (pend_q) begin
                priority if (ge) begin
                  level_d           = less;
                  pend_d            = 1'b0;
                  out_push_o        = 1'b1;
                  out_res_o.status  = ST_GRANTED;
                  out_res_o.granted = pbytes_q;
                end else if (timed) begin
                  pend_d           = 1'b0;
                  out_push_o       = 1'b1;
                  out_res_o.status = ST_TIMEOUT;
                end
              end
            end
          endcase
        end
      end
    endcase
    out_res_o.tokens    = 32'(level_d);
    out_res_o.throttled = thr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      level_q  <= LVL_RST64[TOKEN_WIDTH-1:0];
      shut_q   <= 1'b0;
      pend_q   <= 1'b0;
      waited_q <= '0;
      thr_q    <= '0;
    end else begin
      state_q  <= state_d;
      level_q  <= level_d;
      shut_q   <= shut_d;
      pend_q   <= pend_d;
      waited_q <= waited_d;
      thr_q    <= thr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pbytes_q <= pbytes_d;
    plimit_q <= plimit_d;
    cur_q    <= cur_d;
  end

endmodule

### hdl/token_bucket_rate_limiter.sv
// Token bucket byte-rate limiter, top level: config registers, front end,
// work queue, back end and result queue. Uses tbrl_pkg, tbrl_front, tbrl_fifo, tbrl_back.
//
//   channel   handshake            payload
//   input     push / full          cmd_i, amount_i, wait_limit_ms_i
//   result    empty / pop          status_o, granted_bytes_o, tokens_left_o,
//                                  throttled_total_o
//   config    cfg_we_i             cfg_idx_i, cfg_data_i
//
// Front end takes one transaction per cycle while full is low; its refill divider is
// a 7-stage pipeline that each transaction passes through to reach the work queue.
// Back end runs each transaction through S_LOAD (load and refill), then S_EXEC (decide);
// that sequencer sets the sustained rate. full rises when 8 transactions are
// in flight between input and back end. Results wait in a 2-entry queue; a
// full result queue holds the back end. Reset leaves the bucket full.
module token_bucket_rate_limiter #(
  parameter int unsigned TOKEN_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         cmd_i,
  input  logic [31:0]        amount_i,
  input  logic signed [16:0] wait_limit_ms_i,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         status_o,
  output logic [31:0]        granted_bytes_o,
  output logic [31:0]        tokens_left_o,
  output logic [63:0]        throttled_total_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [31:0]        cfg_data_i
);

  import tbrl_pkg::*;

  localparam int unsigned CW = (TOKEN_WIDTH > 32) ? TOKEN_WIDTH : 32;
  localparam logic [TOKEN_WIDTH-1:0] TOK_MAX = '1;

  logic [31:0]             rate_q, burst_q;
  logic [TOKEN_WIDTH-1:0]  cap;
  logic                    mid_push, mid_pop, mid_empty, mid_full;
  item_t                   mid_wdata, mid_rdata;
  logic [$bits(item_t)-1:0] mid_rbits;
  logic                    out_push, out_full;
  res_t                    out_wdata, out_res;
  logic [$bits(res_t)-1:0] out_rbits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  <= RATE_RST;
      burst_q <= BURST_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RATE:  rate_q  <= cfg_data_i;
        REG_BURST: burst_q <= cfg_data_i;
      endcase
    end
  end

  assign cap = (CW'(burst_q) > CW'(TOK_MAX)) ? TOK_MAX : TOKEN_WIDTH'(burst_q);

  tbrl_front #(
    .TOKEN_WIDTH(TOKEN_WIDTH)
  ) u_front (
    .clk_i,
    .rst_ni,
    .push_i          (push),
    .full_o          (full),
    .cmd_i,
    .amount_i,
    .wait_limit_ms_i,
    .rate_i          (rate_q),
    .cap_i           (cap),
    .mid_pop_i       (mid_pop),
    .mid_push_o      (mid_push),
    .mid_item_o      (mid_wdata)
  );

  tbrl_fifo #(
    .WIDTH($bits(item_t)),
    .DEPTH(MID_DEPTH)
  ) u_mid_q (
    .clk_i,
    .rst_ni,
    .push_i  (mid_push),
    .wdata_i (mid_wdata),
    .pop_i   (mid_pop),
    .rdata_o (mid_rbits),
    .empty_o (mid_empty),
    .full_o  (mid_full)
  );

  assign mid_rdata = item_t'(mid_rbits);

  tbrl_back #(
    .TOKEN_WIDTH(TOKEN_WIDTH)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cap_i       (cap),
    .mid_empty_i (mid_empty),
    .mid_item_i  (mid_rdata),
    .mid_pop_o   (mid_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_res_o   (out_wdata)
  );

  tbrl_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk_i,
    .rst_ni,
    .push_i  (out_push),
    .wdata_i (out_wdata),
    .pop_i   (pop),
    .rdata_o (out_rbits),
    .empty_o (empty),
    .full_o  (out_full)
  );

  assign out_res           = res_t'(out_rbits);
  assign status_o          = out_res.status;
  assign granted_bytes_o   = out_res.granted;
  assign tokens_left_o     = out_res.tokens;
  assign throttled_total_o = out_res.throttled;

`ifndef SYNTH
  a_mid_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_push |-> !mid_full)
    else $error("work queue written while full");

  a_out_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> !out_full)
    else $error("result queue written while full");

  a_refused_no_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != ST_GRANTED) |-> granted_bytes_o == '0)
    else $error("refused result carries granted bytes");
`endif

endmodule

### tb/sv/tbrl_checker.sv
// Result checker for the token bucket rate limiter: watches the input, result and
// config channels, predicts each result and compares it field by field.
// Depends on tbrl_pkg.
module tbrl_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic               full_i,
  input  logic [1:0]         cmd_i,
  input  logic [31:0]        amount_i,
  input  logic signed [16:0] wait_limit_ms_i,
  input  logic               empty_i,
  input  logic               pop_i,
  input  logic [2:0]         status_i,
  input  logic [31:0]        granted_bytes_i,
  input  logic [31:0]        tokens_left_i,
  input  logic [63:0]        throttled_total_i,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  output int                 fail_o,
  output int                 due_o,
  output int                 checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import tbrl_pkg::*;

  logic [31:0]        rate_q;
  logic [31:0]        burst_q;
  logic [63:0]        level_q;
  logic               shut_q;
  logic               pend_q;
  logic [31:0]        pend_bytes_q;
  logic signed [16:0] pend_limit_q;
  logic [63:0]        waited_q;
  logic [63:0]        throttled_q;
  res_t               due_q[$];

  function automatic res_t answer(input status_e st, input logic [31:0] granted);
    res_t r;
    r.status    = st;
    r.granted   = granted;
    r.tokens    = level_q[31:0];
    r.throttled = throttled_q;
    return r;
  endfunction

  // Advance the bucket by one transaction; return 1 when it yields a result.
  function automatic bit bucket_step(input logic [1:0] cmd, input logic [31:0] amount,
                                     input logic signed [16:0] limit, output res_t r);
    logic [31:0] want;
    logic [63:0] elapsed;
    r = '0;
    case (cmd)
      CMD_FETCH: begin
        if (amount == '0) begin
          r = answer(ST_BAD, '0);
          return 1'b1;
        end
        want = (amount > burst_q) ? burst_q : amount;
        if (shut_q) begin
          r = answer(ST_SHUTDOWN, '0);
          return 1'b1;
        end
        if (pend_q) begin
          r = answer(ST_BUSY, '0);
          return 1'b1;
        end
        if (level_q >= 64'(want)) begin
          level_q = level_q - 64'(want);
          r = answer(ST_GRANTED, want);
          return 1'b1;
        end
        throttled_q = throttled_q + 64'(want);
        if (limit == '0) begin
          r = answer(ST_TIMEOUT, '0);
          return 1'b1;
        end
        pend_q       = 1'b1;
        pend_bytes_q = want;
        pend_limit_q = limit;
        waited_q     = '0;
        return 1'b0;
      end
      CMD_TICK: begin
        if (amount == '0) return 1'b0;
        elapsed = (amount > 32'(ELAPSED_MAX)) ? 64'(ELAPSED_MAX) : 64'(amount);
        level_q = level_q + (64'(rate_q) * elapsed) / 64'(MS_PER_S);
        if (level_q > 64'(burst_q)) level_q = 64'(burst_q);
        if (!pend_q) return 1'b0;
        waited_q = waited_q + 64'(amount);
        if (waited_q > 64'hFFFF_FFFF) waited_q = 64'hFFFF_FFFF;
        if (level_q >= 64'(pend_bytes_q)) begin
          level_q = level_q - 64'(pend_bytes_q);
          pend_q  = 1'b0;
          r = answer(ST_GRANTED, pend_bytes_q);
          return 1'b1;
        end
        if (pend_limit_q >= 0 && waited_q >= 64'(pend_limit_q)) begin
          pend_q = 1'b0;
          r = answer(ST_TIMEOUT, '0);
          return 1'b1;
        end
        return 1'b0;
      end
      CMD_SHUT: begin
        shut_q = 1'b1;
        if (pend_q) begin
          pend_q = 1'b0;
          r = answer(ST_SHUTDOWN, '0);
          return 1'b1;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic compare_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t due;
    if (!rst_ni) begin
      rate_q       = RATE_RST;
      burst_q      = BURST_RST;
      level_q      = 64'(BURST_RST);
      shut_q       = 1'b0;
      pend_q       = 1'b0;
      pend_bytes_q = '0;
      pend_limit_q = '0;
      waited_q     = '0;
      throttled_q  = '0;
      due_q.delete();
      fail_o       = 0;
      checked_o    = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_RATE) rate_q = cfg_data_i;
        else burst_q = cfg_data_i;
      end
      if (pop_i && !empty_i) begin
        if (due_q.size() == 0) begin
          $display("%0t: result with nothing expected: status %0d granted %0d tokens %0d",
                   $time, status_i, granted_bytes_i, tokens_left_i);
          fail_o++;
        end else begin
          due = due_q.pop_front();
          compare_field("status", 64'(due.status), 64'(status_i));
          compare_field("granted_bytes", 64'(due.granted), 64'(granted_bytes_i));
          compare_field("tokens_left", 64'(due.tokens), 64'(tokens_left_i));
          compare_field("throttled_total", due.throttled, throttled_total_i);
          checked_o++;
        end
      end
      if (push_i && !full_i && bucket_step(cmd_i, amount_i, wait_limit_ms_i, due))
        due_q.push_back(due);
    end
    due_o = due_q.size();
  end

endmodule

### tb/sv/tb.sv
// Testbench top for the token bucket rate limiter: clock, reset, stimulus,
// config writes and verdict. Depends on tbrl_pkg, tbrl_checker and the limiter RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tbrl_pkg::*;

  localparam int         LIMIT_CYCLES  = 400000;
  localparam int         SETTLE_CYCLES = 48;
  localparam int         PHASE_ITEMS   = 160;
  localparam int         NUM_PHASES    = 10;
  localparam int         TAIL_ITEMS    = 80;
  localparam logic [1:0] CMD_NONE      = 2'd3;
  localparam logic [31:0] MAX32        = 32'hFFFF_FFFF;

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  logic [1:0]         cmd_i;
  logic [31:0]        amount_i;
  logic signed [16:0] wait_limit_ms_i;
  logic               empty;
  logic               pop;
  logic [2:0]         status_o;
  logic [31:0]        granted_bytes_o;
  logic [31:0]        tokens_left_o;
  logic [63:0]        throttled_total_o;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [31:0]        cfg_data_i;

  int          fail_count;
  int          due_count;
  int          checked_count;
  int          cycles;
  int          sent;
  int          settings;
  int          tx_idle;
  int          rx_idle;
  int          stall_left;
  logic [31:0] burst_cfg;

  token_bucket_rate_limiter dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .cmd_i             (cmd_i),
    .amount_i          (amount_i),
    .wait_limit_ms_i   (wait_limit_ms_i),
    .empty             (empty),
    .pop               (pop),
    .status_o          (status_o),
    .granted_bytes_o   (granted_bytes_o),
    .tokens_left_o     (tokens_left_o),
    .throttled_total_o (throttled_total_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i)
  );

  tbrl_checker score (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push),
    .full_i            (full),
    .cmd_i             (cmd_i),
    .amount_i          (amount_i),
    .wait_limit_ms_i   (wait_limit_ms_i),
    .empty_i           (empty),
    .pop_i             (pop),
    .status_i          (status_o),
    .granted_bytes_i   (granted_bytes_o),
    .tokens_left_i     (tokens_left_o),
    .throttled_total_i (throttled_total_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .fail_o            (fail_count),
    .due_o             (due_count),
    .checked_o         (checked_count)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time, due_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stall the result side in random bursts.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      pop <= 1'b0;
    end else if (rx_idle != 0 && $urandom_range(0, rx_idle - 1) == 0) begin
      stall_left <= $urandom_range(0, 14);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic send(input logic [1:0] cmd, input logic [31:0] amount,
                      input logic signed [16:0] limit);
    if (tx_idle != 0 && $urandom_range(0, tx_idle - 1) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    cmd_i           <= cmd;
    amount_i        <= amount;
    wait_limit_ms_i <= limit;
    push            <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
    if (cmd != CMD_NONE) sent++;
  endtask

  task automatic settle();
    push <= 1'b0;
    wait (due_count == 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_rates(input logic [31:0] rate, input logic [31:0] burst);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_RATE;
    cfg_data_i <= rate;
    @(negedge clk_i);
    cfg_idx_i  <= REG_BURST;
    cfg_data_i <= burst;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    burst_cfg  = burst;
    settings++;
  endtask

  // Release any stuck request with a full refill, then apply the new setting.
  task automatic start_phase(input logic [31:0] rate, input logic [31:0] burst);
    write_rates(MAX32, MAX32);
    send(CMD_TICK, 32'd60000, '0);
    write_rates(rate, burst);
  endtask

  task automatic random_item(input bit allow_shut);
    logic [1:0]         cmd;
    logic [31:0]        amount;
    logic signed [16:0] limit;
    int                 pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) cmd = CMD_NONE;
    else if (allow_shut && pick < 6) cmd = CMD_SHUT;
    else if (pick < 53) cmd = CMD_FETCH;
    else cmd = CMD_TICK;
    pick = $urandom_range(0, 99);
    if (cmd == CMD_TICK) begin
      if (pick < 3) amount = '0;
      else if (pick < 10) amount = $urandom();
      else if (pick < 20) amount = $urandom_range(60000, 70000);
      else if (pick < 40) amount = $urandom_range(50, 5000);
      else amount = $urandom_range(1, 50);
    end else begin
      if (pick < 5) amount = '0;
      else if (pick < 15) amount = $urandom();
      else if (pick < 40) amount = $urandom_range(1, burst_cfg);
      else amount = $urandom_range(1, burst_cfg / 8 + 1);
    end
    pick = $urandom_range(0, 99);
    if (pick < 20) limit = -17'sd1;
    else if (pick < 32) limit = '0;
    else if (pick < 90) limit = 17'($urandom_range(1, 300));
    else limit = 17'($urandom_range(0, 65535));
    send(cmd, amount, limit);
  endtask

  initial begin
    logic [31:0] rate;
    logic [31:0] burst;
    int          target;
    rst_ni          = 1'b0;
    push            = 1'b0;
    pop             = 1'b0;
    cmd_i           = CMD_FETCH;
    amount_i        = '0;
    wait_limit_ms_i = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = REG_RATE;
    cfg_data_i      = '0;
    burst_cfg       = BURST_RST;
    tx_idle         = 0;
    rx_idle         = 4;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send(CMD_FETCH, '0, -17'sd1);
    send(CMD_FETCH, MAX32, -17'sd1);
    send(CMD_TICK, '0, '0);
    send(CMD_FETCH, 32'd1000, '0);
    send(CMD_FETCH, 32'd100000, 17'sd5);
    send(CMD_FETCH, 32'd5, -17'sd1);
    send(CMD_FETCH, '0, '0);
    send(CMD_TICK, 32'd1, '0);
    send(CMD_TICK, 32'd4, '0);
    send(CMD_FETCH, BURST_RST, -17'sd1);
    send(CMD_NONE, MAX32, 17'sd65535);
    send(CMD_TICK, MAX32, -17'sd1);
    send(CMD_TICK, 32'd2000, '0);
    send(CMD_FETCH, 32'd1, 17'sd65535);
    send(CMD_FETCH, BURST_RST, 17'sd65535);
    send(CMD_TICK, 32'd60000, '0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin rate = 32'd1; burst = 32'd1; end
        1: begin rate = MAX32; burst = 32'd1; end
        2: begin rate = 32'd1; burst = MAX32; end
        3: begin rate = MAX32; burst = MAX32; end
        default: begin
          rate  = $urandom_range(1000, 20000000);
          burst = $urandom_range(100, 4000000);
        end
      endcase
      tx_idle = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 4 : 16;
      rx_idle = ((p + 1) % 3 == 0) ? 0 : ((p + 1) % 3 == 1) ? 4 : 16;
      start_phase(rate, burst);
      target = sent + PHASE_ITEMS;
      while (sent < target) random_item(1'b0);
    end

    tx_idle = 0;
    rx_idle = 0;
    start_phase(32'd100000, 32'd50000);
    target = sent + TAIL_ITEMS;
    while (sent < target) random_item(1'b0);
    send(CMD_FETCH, MAX32, -17'sd1);
    send(CMD_FETCH, MAX32, -17'sd1);
    send(CMD_SHUT, '0, '0);
    repeat (30) random_item(1'b1);
    send(CMD_SHUT, '0, '0);
    send(CMD_FETCH, '0, -17'sd1);
    send(CMD_FETCH, 32'd5, '0);

    settle();
    $display("Covered %0d input transactions over %0d rate/burst settings, %0d results checked.",
             sent, settings, checked_count);
    $display("Fetch, tick, shutdown and ignored commands were exercised, shutdown last.");
    if (fail_count == 0 && due_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
